/* rtl/jfs_pkg.sv */
// Shared types, constants and a helper function for the JPEG frame size scanner.
package jfs_pkg;

    // Marker and prefix byte values
    localparam logic [7:0] BYTE_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_SOF_LO = 8'hC0;
    localparam logic [7:0] MARK_DHT    = 8'hC4;
    localparam logic [7:0] MARK_JPG    = 8'hC8;
    localparam logic [7:0] MARK_DAC    = 8'hCC;
    localparam logic [7:0] MARK_SOF_HI = 8'hCF;
    localparam logic [7:0] MARK_SOS    = 8'hDA;
    localparam logic [7:0] MARK_EOI    = 8'hD9;

    // Field widths
    localparam int STATUS_W = 3;
    localparam int DIM_W    = 16;
    localparam int OUT_W    = 40;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_NO_SOI   = 3'd1,
        ST_GARBAGE  = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_SCAN_END = 3'd4,
        ST_TRUNC    = 3'd5
    } status_t;

    // Parser phases, one-hot
    typedef enum logic [15:0] {
        PH_SOI1      = 16'h0001,
        PH_SOI2      = 16'h0002,
        PH_SEEK      = 16'h0004,
        PH_MARKER    = 16'h0008,
        PH_LEN_HI    = 16'h0010,
        PH_LEN_LO    = 16'h0020,
        PH_SKIP      = 16'h0040,
        PH_FLEN_HI   = 16'h0080,
        PH_FLEN_LO   = 16'h0100,
        PH_PRECISION = 16'h0200,
        PH_H_HI      = 16'h0400,
        PH_H_LO      = 16'h0800,
        PH_W_HI      = 16'h1000,
        PH_W_LO      = 16'h2000,
        PH_COMPS     = 16'h4000,
        PH_DONE      = 16'h8000
    } phase_t;

    // True for a start-of-frame marker code
    function automatic logic is_frame_marker(input logic [7:0] code);
        is_frame_marker = (code >= MARK_SOF_LO) && (code <= MARK_SOF_HI) &&
                          (code != MARK_DHT) && (code != MARK_JPG) && (code != MARK_DAC);
    endfunction

endpackage

/* rtl/jpeg_frame_size_scanner.sv */
// JPEG frame size scanner: walks marker segments and reports the frame size.
// Path: an accepted byte waits in the input register, then the result register loads
// the result that byte decides; a full result register (m_tready low) holds the byte.
// Throughput: one byte per cycle while the result register is free or draining; the parser state updates once per byte.
// Reset: aresetn is synchronous and active low; it empties both registers and
// puts the parser back to expecting the first start-of-image byte.
module jpeg_frame_size_scanner
    import jfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,   // end_of_file
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // [2:0] status, [18:3] image_width,
                                         // [34:19] image_height, [39:35] zero
);

    // Input register
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;

    // Parser state
    phase_t            phase_reg, phase_next;
    logic              garbage_seen_reg, garbage_seen_next;
    logic [15:0]       skip_count_reg, skip_count_next;
    logic [7:0]        length_high_reg, length_high_next;
    logic [DIM_W-1:0]  frame_height_reg, frame_height_next;
    logic [DIM_W-1:0]  frame_width_reg, frame_width_next;

    // Result register
    logic              m_valid_reg;
    status_t           out_status_reg;
    logic [DIM_W-1:0]  out_width_reg;
    logic [DIM_W-1:0]  out_height_reg;

    logic              pipe_go;
    logic              emit;
    status_t           emit_status;
    logic [15:0]       seg_len;
    logic [15:0]       skip_dec;

    // The buffered item moves on when the result register is free or draining
    assign pipe_go  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || pipe_go;

    assign seg_len  = {length_high_reg, in_byte_reg};
    assign skip_dec = (skip_count_reg != 16'd0) ? skip_count_reg - 16'd1 : skip_count_reg;

    // Parser next-state logic for the buffered byte
    always_comb begin
        phase_next        = phase_reg;
        garbage_seen_next = garbage_seen_reg;
        skip_count_next   = skip_count_reg;
        length_high_next  = length_high_reg;
        frame_height_next = frame_height_reg;
        frame_width_next  = frame_width_reg;
        emit              = 1'b0;
        emit_status       = ST_FOUND;

        case (phase_reg)
            PH_SOI1: begin
                if (in_byte_reg == BYTE_PREFIX) begin
                    phase_next = PH_SOI2;
                end else begin
                    emit        = 1'b1;
                    emit_status = ST_NO_SOI;
                end
            end
            PH_SOI2: begin
                if (in_byte_reg == MARK_SOI) begin
                    phase_next = PH_SEEK;
                end else begin
                    emit        = 1'b1;
                    emit_status = ST_NO_SOI;
                end
            end
            PH_SEEK: begin
                if (in_byte_reg == BYTE_PREFIX) begin
                    phase_next = PH_MARKER;
                end else begin
                    garbage_seen_next = 1'b1;
                end
            end
            PH_MARKER: begin
                // Fill bytes keep the parser waiting for the marker code
                if (in_byte_reg != BYTE_PREFIX) begin
                    if (garbage_seen_reg) begin
                        emit        = 1'b1;
                        emit_status = ST_GARBAGE;
                    end else if (is_frame_marker(in_byte_reg)) begin
                        phase_next = PH_FLEN_HI;
                    end else if (in_byte_reg == MARK_SOS || in_byte_reg == MARK_EOI) begin
                        emit        = 1'b1;
                        emit_status = ST_SCAN_END;
                    end else begin
                        phase_next = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI: begin
                length_high_next = in_byte_reg;
                phase_next       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (seg_len < 16'd2) begin
                    emit        = 1'b1;
                    emit_status = ST_BAD_LEN;
                end else begin
                    skip_count_next = seg_len - 16'd2;
                    phase_next      = (seg_len == 16'd2) ? PH_SEEK : PH_SKIP;
                end
            end
            PH_SKIP: begin
                skip_count_next = skip_dec;
                if (skip_dec == 16'd0) begin
                    phase_next = PH_SEEK;
                end
            end
            PH_FLEN_HI:   phase_next = PH_FLEN_LO;
            PH_FLEN_LO:   phase_next = PH_PRECISION;
            PH_PRECISION: phase_next = PH_H_HI;
            PH_H_HI: begin
                frame_height_next = {in_byte_reg, 8'h00};
                phase_next        = PH_H_LO;
            end
            PH_H_LO: begin
                frame_height_next = {frame_height_reg[15:8], in_byte_reg};
                phase_next        = PH_W_HI;
            end
            PH_W_HI: begin
                frame_width_next = {in_byte_reg, 8'h00};
                phase_next       = PH_W_LO;
            end
            PH_W_LO: begin
                frame_width_next = {frame_width_reg[15:8], in_byte_reg};
                phase_next       = PH_COMPS;
            end
            PH_COMPS: begin
                emit        = 1'b1;
                emit_status = ST_FOUND;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (emit) begin
            phase_next = PH_DONE;
        end

        // The last byte of a file reports truncation if undecided, then restarts
        if (in_last_reg) begin
            if (!emit && phase_next != PH_DONE) begin
                emit        = 1'b1;
                emit_status = ST_TRUNC;
            end
            phase_next        = PH_SOI1;
            garbage_seen_next = 1'b0;
            skip_count_next   = 16'd0;
            length_high_next  = 8'h00;
            frame_height_next = '0;
            frame_width_next  = '0;
        end
    end

    // Input register: takes a new item when it is empty or the previous one moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Parser state update, once per processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SOI1;
            garbage_seen_reg <= 1'b0;
            skip_count_reg   <= 16'd0;
            length_high_reg  <= 8'h00;
            frame_height_reg <= '0;
            frame_width_reg  <= '0;
        end else if (pipe_go) begin
            phase_reg        <= phase_next;
            garbage_seen_reg <= garbage_seen_next;
            skip_count_reg   <= skip_count_next;
            length_high_reg  <= length_high_next;
            frame_height_reg <= frame_height_next;
            frame_width_reg  <= frame_width_next;
        end
    end

    // Result register: the size is only reported with a found status.
    // The size is taken before the last byte of a file clears it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_go) begin
            m_valid_reg <= emit;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (pipe_go && emit) begin
            out_status_reg <= emit_status;
            if (emit_status == ST_FOUND) begin
                out_width_reg  <= frame_width_reg;
                out_height_reg <= frame_height_reg;
            end else begin
                out_width_reg  <= '0;
                out_height_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, out_height_reg, out_width_reg, out_status_reg};

`ifndef SYNTHESIS
    // A failed or truncated file never carries a size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg != ST_FOUND) |->
            (out_width_reg == '0 && out_height_reg == '0))
        else $error("size reported with a non-found status");

    // The last byte of a file always returns the parser to its start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_go && in_last_reg) |=> (phase_reg == PH_SOI1 && !garbage_seen_reg))
        else $error("parser did not restart after the last byte");

    // While skipping payload there is always at least one byte left to skip
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SKIP) |-> (skip_count_reg != 16'd0))
        else $error("skip phase entered with nothing to skip");

    // A status code stays within the defined set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_status_reg <= ST_TRUNC))
        else $error("undefined status code on the result");
`endif

endmodule
